/* rtl/core/vupb_pkg.sv */
// Shared types and constants for the VU meter bar with peak hold.
// Used by every module of the block; depends on nothing else.
package vupb_pkg;

  // Default half segment length, in LEDs.
  localparam int unsigned HalfLedsDef = 16;

  // Depth of the queue between the front end and the executor.
  localparam int unsigned QueueDepth = 2;

  // Request codes carried by req_type.
  localparam logic ReqBeat   = 1'b0;
  localparam logic ReqRender = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CfgStepPeriod = 2'd0;
  localparam logic [1:0] CfgThreshold  = 2'd1;
  localparam logic [1:0] CfgSilence    = 2'd2;

  // Configuration reset values.
  localparam logic [15:0] StepPeriodRst = 16'd20;
  localparam logic [6:0]  ThresholdRst  = 7'd5;
  localparam logic [15:0] SilenceRst    = 16'd1000;

  typedef struct packed {
    logic [15:0] step_period_ms;
    logic [15:0] silence_timeout_ms;
  } vupb_cfg_t;

  // One classified word in the queue.
  typedef struct packed {
    logic        is_render;
    logic [7:0]  width;
    logic [31:0] now_ms;
  } vupb_item_t;

  // State picture handed to the LED emitter at the start of a frame.
  typedef struct packed {
    logic signed [7:0] bar_width;
    logic signed [7:0] peak_pos;
    logic [15:0]       runner_offset;
  } vupb_snap_t;

endpackage

/* rtl/core/vupb_front.sv */
// Front end: accepts input words, drops beats below threshold and turns the
// beat level into a bar width through a constant table. Uses vupb_pkg.
module vupb_front import vupb_pkg::*; #(
  parameter int unsigned HALF_LEDS = HalfLedsDef
) (
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [6:0]  beat_level_i,
  input  logic [31:0] now_ms_i,
  input  logic [6:0]  beat_threshold_i,
  input  logic        q_full_i,
  output logic        push_o,
  output vupb_item_t  push_item_o
);

  typedef logic [127:0][7:0] wtbl_t;

  // Level to width, with levels above one hundred saturated.
  function automatic wtbl_t build_tbl();
    wtbl_t       t;
    int unsigned lv;
    for (int l = 0; l < 128; l++) begin
      lv   = (l > 100) ? 100 : l;
      t[l] = 8'((lv * HALF_LEDS) / 100);
    end
    return t;
  endfunction

  localparam wtbl_t WidthTbl = build_tbl();

  logic keep;

  assign in_ready_o = !q_full_i;
  assign keep       = (req_type_i == ReqRender) || (beat_level_i >= beat_threshold_i);
  assign push_o     = in_valid_i && !q_full_i && keep;

  assign push_item_o.is_render = (req_type_i == ReqRender);
  assign push_item_o.width     = WidthTbl[beat_level_i];
  assign push_item_o.now_ms    = now_ms_i;

endmodule

/* rtl/core/vupb_queue.sv */
// Short queue of classified words between the front end and the executor.
// Uses vupb_pkg for the word type and the depth.
module vupb_queue import vupb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  vupb_item_t push_item_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output vupb_item_t head_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  vupb_item_t          mem_q [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_pop;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

/* rtl/core/vupb_exec.sv */
// Executor: holds the meter state, applies beats and runs the animation
// step of each frame after handing a state picture to the emitter.
// Uses vupb_pkg.
module vupb_exec import vupb_pkg::*; #(
  parameter int unsigned HALF_LEDS = HalfLedsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  vupb_cfg_t  cfg_i,
  input  logic       q_valid_i,
  input  vupb_item_t head_i,
  output logic       pop_o,
  input  logic       load_ready_i,
  output logic       load_o,
  output vupb_snap_t snap_o
);

  typedef enum logic {ExFetch, ExApply} ex_state_e;

  localparam logic signed [7:0] HalfS  = 8'(HALF_LEDS);
  localparam logic signed [7:0] ThirdS = 8'(HALF_LEDS / 3);

  ex_state_e         state_q, state_d;
  logic signed [7:0] bar_q, bar_d, peak_q, peak_d;
  logic signed [7:0] peak_m1, bar_p1;
  logic [15:0]       runner_q, runner_d;
  logic [31:0]       peak_t_q, peak_t_d, step_t_q, step_t_d, beat_t_q, beat_t_d;
  logic              silent_q, silent_d, peak_due_q, peak_due_d;
  logic              step1_q, step1_d, step2_q, step2_d;
  logic [31:0]       d_beat, d_peak, d_step;
  logic [17:0]       p3, p2;

  assign d_beat = head_i.now_ms - beat_t_q;
  assign d_peak = head_i.now_ms - peak_t_q;
  assign d_step = head_i.now_ms - step_t_q;
  assign p2     = {1'b0, cfg_i.step_period_ms, 1'b0};
  assign p3     = p2 + {2'b00, cfg_i.step_period_ms};
  assign peak_m1 = peak_q - 8'sd1;
  assign bar_p1  = bar_q + 8'sd1;

  assign snap_o.bar_width     = bar_q;
  assign snap_o.peak_pos      = peak_q;
  assign snap_o.runner_offset = runner_q;

  always_comb begin
    state_d    = state_q;
    bar_d      = bar_q;
    peak_d     = peak_q;
    runner_d   = runner_q;
    peak_t_d   = peak_t_q;
    step_t_d   = step_t_q;
    beat_t_d   = beat_t_q;
    silent_d   = silent_q;
    peak_due_d = peak_due_q;
    step1_d    = step1_q;
    step2_d    = step2_q;
    pop_o      = 1'b0;
    load_o     = 1'b0;
    unique case (state_q)
      ExFetch: begin
        if (q_valid_i) begin
          if (!head_i.is_render) begin
            bar_d = $signed(head_i.width);
            if (peak_q < $signed(head_i.width)) begin
              peak_d = $signed(head_i.width);
            end
            beat_t_d = head_i.now_ms;
            pop_o    = 1'b1;
          end else if (load_ready_i) begin
            // The emitter takes the state as it stands before this frame.
            load_o     = 1'b1;
            silent_d   = d_beat > {16'd0, cfg_i.silence_timeout_ms};
            peak_due_d = d_peak > {14'd0, p3};
            step1_d    = d_step > {16'd0, cfg_i.step_period_ms};
            step2_d    = d_step > {14'd0, p2};
            state_d    = ExApply;
          end
        end
      end
      ExApply: begin
        pop_o   = 1'b1;
        state_d = ExFetch;
        if (silent_q) begin
          if (peak_due_q) begin
            peak_t_d = head_i.now_ms;
            if (peak_m1 <= bar_q) begin
              peak_d = HalfS;
              bar_d  = (bar_p1 >= HalfS) ? 8'sd0 : bar_p1;
            end else begin
              peak_d = peak_m1;
            end
          end
          if (step2_q) begin
            runner_d = runner_q + 16'd1;
            step_t_d = head_i.now_ms;
          end
        end else begin
          if (peak_due_q) begin
            peak_t_d = head_i.now_ms;
            if (peak_q > 8'sd0) begin
              peak_d = peak_m1;
            end
          end
          if (step1_q) begin
            step_t_d = head_i.now_ms;
            if (bar_q > ThirdS) begin
              runner_d = runner_q + 16'd1;
            end
            if (bar_q >= 8'sd0) begin
              bar_d = bar_q - 8'sd1;
            end
          end
        end
      end
      default: state_d = ExFetch;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ExFetch;
      bar_q      <= '0;
      peak_q     <= '0;
      runner_q   <= '0;
      peak_t_q   <= '0;
      step_t_q   <= '0;
      beat_t_q   <= '0;
      silent_q   <= 1'b0;
      peak_due_q <= 1'b0;
      step1_q    <= 1'b0;
      step2_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      bar_q      <= bar_d;
      peak_q     <= peak_d;
      runner_q   <= runner_d;
      peak_t_q   <= peak_t_d;
      step_t_q   <= step_t_d;
      beat_t_q   <= beat_t_d;
      silent_q   <= silent_d;
      peak_due_q <= peak_due_d;
      step1_q    <= step1_d;
      step2_q    <= step2_d;
    end
  end

endmodule

/* rtl/core/vupb_emit.sv */
// LED emitter: walks both half segments of one frame from a state picture,
// one LED word per cycle while out_ready_i is high, mirroring the second half. Uses vupb_pkg.
module vupb_emit import vupb_pkg::*; #(
  parameter int unsigned HALF_LEDS = HalfLedsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  vupb_snap_t  snap_i,
  output logic        load_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  led_index_o,
  output logic        led_lit_o,
  output logic [15:0] palette_pos_o,
  output logic        last_led_o
);

  localparam int unsigned IdxW = $clog2(2 * HALF_LEDS);
  localparam int unsigned HW   = IdxW - 1;

  vupb_snap_t      snap_q;
  logic [IdxW-1:0] idx_q, mirror;
  logic            busy_q, last, done;
  logic [HW-1:0]   h;

  assign last   = (idx_q == IdxW'(2 * HALF_LEDS - 1));
  assign mirror = IdxW'(2 * HALF_LEDS - 1) - idx_q;
  assign h      = (idx_q < IdxW'(HALF_LEDS)) ? idx_q[HW-1:0] : mirror[HW-1:0];
  assign done   = busy_q && out_ready_i && last;

  assign load_ready_o  = !busy_q || done;
  assign out_valid_o   = busy_q;
  assign led_index_o   = 6'(idx_q);
  assign led_lit_o     = ($signed(8'(h)) <= snap_q.bar_width) ||
                         ($signed(8'(h)) == snap_q.peak_pos);
  assign palette_pos_o = led_lit_o ? (16'(h) + snap_q.runner_offset) : 16'd0;
  assign last_led_o    = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (busy_q && out_ready_i) begin
      if (last) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      snap_q <= snap_i;
    end
  end

endmodule

/* rtl/core/vu_meter_peak_hold_bar.sv */
// A render word gives 2*HALF_LEDS LED words, one per cycle while out_ready_i is
// high. Between its acceptance and the first word lie the queue registers and
// the emitter's busy and snapshot registers; frames follow without a gap.
// Beats apply in ExFetch, frames in ExFetch then ExApply, behind a two-word queue.
// Reset clears the meter state and returns the registers to their defaults.
// Top level: configuration registers, front end, queue, executor and emitter.
module vu_meter_peak_hold_bar import vupb_pkg::*; #(
  parameter int unsigned HALF_LEDS = HalfLedsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [6:0]  beat_level_i,
  input  logic [31:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  led_index_o,
  output logic        led_lit_o,
  output logic [15:0] palette_pos_o,
  output logic        last_led_o
);

  logic [15:0] step_period_q, silence_q;
  logic [6:0]  threshold_q;
  vupb_cfg_t   cfg;
  logic        q_full, push, q_valid, pop, load_ready, load;
  vupb_item_t  push_item, head;
  vupb_snap_t  snap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_period_q <= StepPeriodRst;
      threshold_q   <= ThresholdRst;
      silence_q     <= SilenceRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgStepPeriod: step_period_q <= cfg_data_i;
        CfgThreshold:  threshold_q   <= cfg_data_i[6:0];
        CfgSilence:    silence_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg.step_period_ms     = step_period_q;
  assign cfg.silence_timeout_ms = silence_q;

  vupb_front #(.HALF_LEDS(HALF_LEDS)) u_front (
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .beat_level_i     (beat_level_i),
    .now_ms_i         (now_ms_i),
    .beat_threshold_i (threshold_q),
    .q_full_i         (q_full),
    .push_o           (push),
    .push_item_o      (push_item)
  );

  vupb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (head)
  );

  vupb_exec #(.HALF_LEDS(HALF_LEDS)) u_exec (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .q_valid_i    (q_valid),
    .head_i       (head),
    .pop_o        (pop),
    .load_ready_i (load_ready),
    .load_o       (load),
    .snap_o       (snap)
  );

  vupb_emit #(.HALF_LEDS(HALF_LEDS)) u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .snap_i        (snap),
    .load_ready_o  (load_ready),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .led_index_o   (led_index_o),
    .led_lit_o     (led_lit_o),
    .palette_pos_o (palette_pos_o),
    .last_led_o    (last_led_o)
  );

endmodule
